// ===== rtl/ifag_pkg.sv =====
// Shared types and constants for the inverse-frequency accept gate.
`default_nettype none

package ifag_pkg;

  localparam int ACT_W = 12;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_COMPUTE = 2'd1,
    OP_QUERY   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LO_DIV,
    ST_CLAMP,
    ST_W_DIV,
    ST_C_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [9:0]  slot;
    logic [31:0] call_count;
    logic [5:0]  roll;
  } in_item_t;

  typedef struct packed {
    logic        accept;
    logic [6:0]  weight;
    logic [31:0] baseline_out;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/ifag_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ifag_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ifag_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module ifag_div #(
  parameter int NUM_W = 42,
  parameter int DVS_W = 36
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [$clog2(NUM_W+1)-1:0] bits,
  input  wire logic [NUM_W-1:0]           num,
  input  wire logic [DVS_W-1:0]           dvs,
  output      logic                       done,
  output      logic [NUM_W-1:0]           quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] num_sr;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             ge;

  // Shift in the next numerator bit, try the subtract.
  always_comb begin
    rem_sh  = {rem, num_sr[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    ge      = (rem_sh >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= bits;
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient bits replace numerator bits from the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      num_sr <= num;
      dvs_r  <= dvs;
      rem    <= '0;
    end else if (busy) begin
      num_sr <= {num_sr[NUM_W-2:0], ge};
      rem    <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign quot = num_sr;

endmodule

`default_nettype wire

// ===== rtl/inverse_frequency_accept_gate_unit.sv =====
// Top level of the inverse-frequency accept gate: control, state and result register.
//
//  channel | signals                          | moves a word when
//  --------+----------------------------------+-----------------------------
//  cfg     | cfg_wr_en, cfg_wr_data           | cfg_wr_en high
//  in      | in_valid, in_ready, in_data      | in_valid and in_ready high
//  out     | out_valid, out_ready, out_data   | out_valid and out_ready high
//
// Sequencing: load and unused codes go straight to the finish state; compute runs one
// pass of the serial divider (SUM_BITS quotient bits, one quotient bit a cycle), or none
// with a zero divisor; query runs two divider passes (COUNT_BITS, then COUNT_BITS +
// clog2(BOOST+1) bits), or none while the baseline is zero or the slot is out of range.
// Reset: a clearing pass writes zero to every one of the SLOTS slot counts, with
// in_ready low; configuration writes are taken throughout.
// Stalls: the result register holds a finished word while the next word is accepted;
// a word that finishes meanwhile waits until the result register frees.
`default_nettype none

module inverse_frequency_accept_gate_unit #(
  parameter int SLOTS      = 1024,
  parameter int BOOST      = 8,
  parameter int COUNT_BITS = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wr_en,
  input  wire logic [ifag_pkg::ACT_W-1:0] cfg_wr_data,
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire ifag_pkg::in_item_t        in_data,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      ifag_pkg::out_item_t       out_data
);

  import ifag_pkg::*;

  localparam int SLOT_AW  = $clog2(SLOTS);
  localparam int SUM_BITS = COUNT_BITS + 10;
  localparam int BOOST_W  = $clog2(BOOST + 1);
  localparam int W_BITS   = COUNT_BITS + BOOST_W;
  localparam int DVS_W    = (W_BITS > ACT_W) ? W_BITS : ACT_W;
  localparam int NUM_W    = (SUM_BITS > W_BITS) ? SUM_BITS : W_BITS;
  localparam int CNT_W    = $clog2(NUM_W + 1);
  localparam int CAP      = BOOST * BOOST;
  localparam int WGT_W    = $clog2(CAP + 1);
  localparam int C_SHIFT  = NUM_W - SUM_BITS;
  localparam int LO_SHIFT = NUM_W - COUNT_BITS;
  localparam int W_SHIFT  = NUM_W - W_BITS;

  state_t state, state_next;

  logic [SUM_BITS-1:0]   count_sum;
  logic [COUNT_BITS-1:0] mean_baseline;
  logic [ACT_W-1:0]      active_count;
  logic [SLOT_AW-1:0]    clr_addr;
  logic [5:0]            item_roll;
  logic                  res_acc;
  logic [WGT_W-1:0]      res_wgt;

  // Control decode
  logic               out_load;
  logic               div_start;
  logic [CNT_W-1:0]   div_bits;
  logic [NUM_W-1:0]   div_num;
  logic [DVS_W-1:0]   div_dvs;
  logic               div_done;
  logic [NUM_W-1:0]   quot;
  logic               ram_we;
  logic [SLOT_AW-1:0] ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic               ram_re;
  logic [COUNT_BITS-1:0] ram_rdata;

  // Datapath helpers
  op_t                   op;
  logic                  in_range;
  logic [COUNT_BITS-1:0] cnt_in;
  logic [SUM_BITS:0]     sum_add;
  logic [DVS_W-1:0]      hi;
  logic [COUNT_BITS-1:0] lo_v;
  logic [DVS_W-1:0]      lo_ext;
  logic [DVS_W-1:0]      c_raw;
  logic [DVS_W-1:0]      c_clamp;
  logic [WGT_W-1:0]      wgt_v;
  logic [COUNT_BITS-1:0] base_v;
  logic                  item_accept;

  always_comb begin
    op       = op_t'(in_data.operation);
    in_range = (int'(in_data.slot) < SLOTS);
    cnt_in   = COUNT_BITS'(in_data.call_count);
    sum_add  = {1'b0, count_sum} + (SUM_BITS + 1)'(cnt_in);
    // Clamp window for the query: [max(1, b/BOOST), b*BOOST].
    hi       = DVS_W'(mean_baseline) * DVS_W'(BOOST);
    lo_v     = quot[COUNT_BITS-1:0];
    lo_ext   = (lo_v == '0) ? DVS_W'(1) : DVS_W'(lo_v);
    c_raw    = DVS_W'(ram_rdata);
    if (c_raw < lo_ext) begin
      c_clamp = lo_ext;
    end else if (c_raw > hi) begin
      c_clamp = hi;
    end else begin
      c_clamp = c_raw;
    end
    // Cap the weight at BOOST squared.
    wgt_v = (quot > NUM_W'(CAP)) ? WGT_W'(CAP) : WGT_W'(quot);
    // Raise a truncated-to-zero mean to 1, saturate at the count width.
    if (quot == '0 && count_sum != '0) begin
      base_v = COUNT_BITS'(1);
    end else if (quot[NUM_W-1:COUNT_BITS] != '0) begin
      base_v = '1;
    end else begin
      base_v = quot[COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    div_start  = 1'b0;
    div_bits   = '0;
    div_num    = '0;
    div_dvs    = '0;
    ram_we     = 1'b0;
    ram_waddr  = clr_addr;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_addr == SLOT_AW'(SLOTS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_FINISH;
          unique case (op)
            OP_LOAD: begin
              ram_we    = in_range;
              ram_waddr = SLOT_AW'(in_data.slot);
              ram_wdata = cnt_in;
            end
            OP_COMPUTE: begin
              if (active_count != '0) begin
                div_start  = 1'b1;
                div_bits   = CNT_W'(SUM_BITS);
                div_num    = NUM_W'(count_sum) << C_SHIFT;
                div_dvs    = DVS_W'(active_count);
                state_next = ST_C_DIV;
              end
            end
            OP_QUERY: begin
              if (mean_baseline != '0 && in_range) begin
                ram_re     = 1'b1;
                div_start  = 1'b1;
                div_bits   = CNT_W'(COUNT_BITS);
                div_num    = NUM_W'(mean_baseline) << LO_SHIFT;
                div_dvs    = DVS_W'(BOOST);
                state_next = ST_LO_DIV;
              end
            end
            default: begin
              state_next = ST_FINISH;
            end
          endcase
        end
      end
      ST_LO_DIV: begin
        if (div_done) begin
          state_next = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        div_start  = 1'b1;
        div_bits   = CNT_W'(W_BITS);
        div_num    = NUM_W'(hi) << W_SHIFT;
        div_dvs    = c_clamp;
        state_next = ST_W_DIV;
      end
      ST_W_DIV: begin
        if (div_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_C_DIV: begin
        if (div_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Hold the result until the output register frees.
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  assign item_accept = in_valid && in_ready;

  // Control state: counts, baseline, configuration, clearing sweep, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count_sum     <= '0;
      mean_baseline <= '0;
      active_count  <= '0;
      clr_addr      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        active_count <= cfg_wr_data;
      end
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + SLOT_AW'(1);
      end
      if (item_accept && op == OP_LOAD && in_range) begin
        // Saturate the running sum on overflow.
        count_sum <= sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
      end
      if (item_accept && op == OP_COMPUTE && active_count == '0) begin
        mean_baseline <= '0;
        count_sum     <= '0;
      end
      if (state == ST_C_DIV && div_done) begin
        mean_baseline <= base_v;
        count_sum     <= '0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (item_accept) begin
      item_roll <= in_data.roll;
      if (op == OP_QUERY) begin
        // Baseline zero or slot out of range: accept unconditionally.
        res_acc <= 1'b1;
        res_wgt <= WGT_W'(CAP);
      end else begin
        res_acc <= 1'b0;
        res_wgt <= '0;
      end
    end
    if (state == ST_W_DIV && div_done) begin
      res_wgt <= wgt_v;
      res_acc <= (NUM_W'(item_roll) < NUM_W'(wgt_v));
    end
    if (out_load) begin
      out_data.accept       <= res_acc;
      out_data.weight       <= 7'(res_wgt);
      out_data.baseline_out <= 32'(mean_baseline);
    end
  end

  ifag_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(SLOTS)
  ) u_counts (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(SLOT_AW'(in_data.slot)),
    .rdata(ram_rdata)
  );

  ifag_div #(
    .NUM_W(NUM_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .bits (div_bits),
    .num  (div_num),
    .dvs  (div_dvs),
    .done (div_done),
    .quot (quot)
  );

endmodule

`default_nettype wire
